// ===== rtl/ablsel_pkg.sv =====
// ----------------------------------------------------------------------------
// ablsel_pkg
// Shared widths, codes and controller/datapath handshake types for the
// adaptive bitrate level selector.
// ----------------------------------------------------------------------------
package ablsel_pkg;

    localparam int NUM_LEVELS_DEF = 4;
    localparam int RATE_W = 40;
    localparam int TIME_W = 40;
    localparam int BYTES_W = 48;
    localparam int CNT_W = 32;
    localparam int SEG_W = 16;
    localparam int DIVN_W = 61;
    localparam int DIVD_W = 40;
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [RATE_W-1:0] MAX40 = {RATE_W{1'b1}};

    // register indices
    localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
    localparam logic [2:0] REG_RATE_0 = 3'd1;
    localparam logic [2:0] REG_RATE_1 = 3'd2;
    localparam logic [2:0] REG_RATE_2 = 3'd3;
    localparam logic [2:0] REG_RATE_3 = 3'd4;
    localparam logic [2:0] REG_SEGMENT = 3'd5;
    localparam logic [2:0] REG_CONTENT = 3'd6;

    localparam logic CMD_AUTO = 1'b0;
    localparam logic CMD_MANUAL = 1'b1;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_SWITCH = 2'd1;
    localparam logic [1:0] ACT_RETRY = 2'd2;

    localparam logic [1:0] PB_READY = 2'd1;
    localparam logic [1:0] PB_REBUFFER = 2'd2;

    localparam logic [1:0] SS_STABLE = 2'd0;
    localparam logic [1:0] SS_FAILED = 2'd1;

    localparam logic [2:0] RSN_NONE = 3'd0;
    localparam logic [2:0] RSN_BACKOFF = 3'd1;
    localparam logic [2:0] RSN_FAILED = 3'd2;
    localparam logic [2:0] RSN_REBUF_DOWN = 3'd3;
    localparam logic [2:0] RSN_TPUT_DOWN = 3'd4;
    localparam logic [2:0] RSN_UPGRADE = 3'd5;
    localparam logic [2:0] RSN_MANUAL = 3'd6;

    typedef struct packed {
        logic [2:0]             level_count;
        logic [3:0][RATE_W-1:0] rate;
        logic [SEG_W-1:0]       seg;
        logic [TIME_W-1:0]      content;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic pre;
        logic obs;
        logic mapply;
        logic decide;
        logic sw;
        logic bmul;
        logic bchk;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pre_sw;
        logic pre_obs;
        logic obs_meas;
        logic dec_sw;
        logic sw_div;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/adaptive_bitrate_level_selector_top.sv =====
// ----------------------------------------------------------------------------
// adaptive_bitrate_level_selector_top
// Throughput-driven quality level selector with APB register bank.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one observation or manual request per word (valid/ready);
//   m_* returns exactly one decision word per input word.
//   Levels, segment and content length are set over APB while idle;
//   registers lie at 8*i, 64-bit data, pready tied high.
// Sequence:
//   a word is accepted, decided, then loaded into the output register, which
//   raises m_valid; measuring throughput adds a divide and computing a switch
//   boundary adds another. Each division holds the sequencer in the shared
//   bit-serial divider for its 61 quotient bits and its done pulse.
//   One word is in work at a time.
// Stall: a finished decision waits in the output register; the next word
//   is accepted meanwhile and, when done, waits until m_ready frees the slot.
// Reset: aresetn (synchronous, active low) clears registers, estimator,
//   timers, backoff and counters; no word is pending afterwards.
// ----------------------------------------------------------------------------
module adaptive_bitrate_level_selector_top import ablsel_pkg::*; #(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic [BYTES_W-1:0] s_downloaded_bytes,
    input  logic [RATE_W-1:0]  s_reported_rate_bps,
    input  logic [2:0]         s_active_level,
    input  logic [1:0]         s_playback_status,
    input  logic [1:0]         s_switch_status,
    input  logic [CNT_W-1:0]   s_switch_count,
    input  logic [CNT_W-1:0]   s_switch_generation,
    input  logic [TIME_W-1:0]  s_presentation_ms,
    input  logic [2:0]         s_target_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_action,
    output logic [1:0]         m_chosen_level,
    output logic [TIME_W-1:0]  m_boundary_ms,
    output logic [TIME_W-1:0]  m_retry_ms,
    output logic               m_cancel_failed,
    output logic [2:0]         m_reason_code,
    output logic [RATE_W-1:0]  m_smoothed_rate_bps
);
    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic [2:0] idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx = paddr[5:3];
    assign wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_LEVEL_COUNT: cfg_reg.level_count <= pwdata[2:0];
                REG_RATE_0:      cfg_reg.rate[0] <= pwdata[RATE_W-1:0];
                REG_RATE_1:      cfg_reg.rate[1] <= pwdata[RATE_W-1:0];
                REG_RATE_2:      cfg_reg.rate[2] <= pwdata[RATE_W-1:0];
                REG_RATE_3:      cfg_reg.rate[3] <= pwdata[RATE_W-1:0];
                REG_SEGMENT:     cfg_reg.seg <= pwdata[SEG_W-1:0];
                REG_CONTENT:     cfg_reg.content <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_LEVEL_COUNT: prdata = {61'd0, cfg_reg.level_count};
            REG_RATE_0:      prdata = {24'd0, cfg_reg.rate[0]};
            REG_RATE_1:      prdata = {24'd0, cfg_reg.rate[1]};
            REG_RATE_2:      prdata = {24'd0, cfg_reg.rate[2]};
            REG_RATE_3:      prdata = {24'd0, cfg_reg.rate[3]};
            REG_SEGMENT:     prdata = {48'd0, cfg_reg.seg};
            REG_CONTENT:     prdata = {24'd0, cfg_reg.content};
            default:         prdata = '0;
        endcase
    end

    ablsel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ablsel_dp #(.NUM_LEVELS(NUM_LEVELS)) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg                 (cfg_reg),
        .s_command           (s_command),
        .s_now_ms            (s_now_ms),
        .s_downloaded_bytes  (s_downloaded_bytes),
        .s_reported_rate_bps (s_reported_rate_bps),
        .s_active_level      (s_active_level),
        .s_playback_status   (s_playback_status),
        .s_switch_status     (s_switch_status),
        .s_switch_count      (s_switch_count),
        .s_switch_generation (s_switch_generation),
        .s_presentation_ms   (s_presentation_ms),
        .s_target_level      (s_target_level),
        .m_action            (m_action),
        .m_chosen_level      (m_chosen_level),
        .m_boundary_ms       (m_boundary_ms),
        .m_retry_ms          (m_retry_ms),
        .m_cancel_failed     (m_cancel_failed),
        .m_reason_code       (m_reason_code),
        .m_smoothed_rate_bps (m_smoothed_rate_bps)
    );
endmodule

// ===== rtl/ablsel_div.sv =====
// ----------------------------------------------------------------------------
// ablsel_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module ablsel_div #(
    parameter int N = 61,
    parameter int D = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic [N-1:0] quotient,
    output logic         done
);
    localparam int CW = $clog2(N);
    localparam logic [CW-1:0] LAST = CW'(N - 1);

    logic [N-1:0]  q_reg, q_next;
    logic [D-1:0]  r_reg, r_next;
    logic [D-1:0]  d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [D:0]    sh, diff;
    logic          ge;

    always_comb begin
        sh = {r_reg, q_reg[N-1]};
        diff = sh - {1'b0, d_reg};
        ge = sh >= {1'b0, d_reg};
        r_next = ge ? diff[D-1:0] : sh[D-1:0];
        q_next = {q_reg[N-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient = q_reg;
    assign done = done_reg;
endmodule

// ===== rtl/ablsel_ctrl.sv =====
// ----------------------------------------------------------------------------
// ablsel_ctrl
// Sequencer for one word: decision phases, divider waits, result hand-off.
// ----------------------------------------------------------------------------
module ablsel_ctrl import ablsel_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_PRE    = 11'b00000000010,
        ST_OBS    = 11'b00000000100,
        ST_MDIV   = 11'b00000001000,
        ST_MAPPLY = 11'b00000010000,
        ST_DECIDE = 11'b00000100000,
        ST_SW     = 11'b00001000000,
        ST_BDIV   = 11'b00010000000,
        ST_BMUL   = 11'b00100000000,
        ST_BCHK   = 11'b01000000000,
        ST_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   slot_free;

    assign slot_free = !mvalid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) state_next = ST_PRE;
            end
            ST_PRE: begin
                cmd.pre = 1'b1;
                if (sts.pre_sw) state_next = ST_SW;
                else if (sts.pre_obs) state_next = ST_OBS;
                else state_next = ST_OUT;
            end
            ST_OBS: begin
                cmd.obs = 1'b1;
                cmd.div_start = sts.obs_meas;
                state_next = sts.obs_meas ? ST_MDIV : ST_DECIDE;
            end
            ST_MDIV: begin
                if (sts.div_done) state_next = ST_MAPPLY;
            end
            ST_MAPPLY: begin
                cmd.mapply = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.dec_sw ? ST_SW : ST_OUT;
            end
            ST_SW: begin
                cmd.sw = 1'b1;
                cmd.div_start = sts.sw_div;
                state_next = sts.sw_div ? ST_BDIV : ST_OUT;
            end
            ST_BDIV: begin
                if (sts.div_done) state_next = ST_BMUL;
            end
            ST_BMUL: begin
                cmd.bmul = 1'b1;
                state_next = ST_BCHK;
            end
            ST_BCHK: begin
                cmd.bchk = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_load = slot_free;
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (m_ready) mvalid_next = 1'b0;
        if (cmd.out_load) mvalid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

`ifndef ASSERT_OFF
    a_div_start_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (state_reg == ST_OBS || state_reg == ST_SW))
        else $error("divider started outside a dividing phase");
    a_mdiv_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MDIV && sts.div_done) |=> state_reg == ST_MAPPLY)
        else $error("measurement divide did not hand over");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !m_ready) |=> !$past(cmd.out_load))
        else $error("pending result overwritten");
`endif
endmodule

// ===== rtl/ablsel_dp.sv =====
// ----------------------------------------------------------------------------
// ablsel_dp
// Datapath: captured word, estimator and timer state, decision logic,
// shared divider and result registers.
// ----------------------------------------------------------------------------
module ablsel_dp import ablsel_pkg::*; #(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  cfg_t               cfg,
    input  logic               s_command,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic [BYTES_W-1:0] s_downloaded_bytes,
    input  logic [RATE_W-1:0]  s_reported_rate_bps,
    input  logic [2:0]         s_active_level,
    input  logic [1:0]         s_playback_status,
    input  logic [1:0]         s_switch_status,
    input  logic [CNT_W-1:0]   s_switch_count,
    input  logic [CNT_W-1:0]   s_switch_generation,
    input  logic [TIME_W-1:0]  s_presentation_ms,
    input  logic [2:0]         s_target_level,
    output logic [1:0]         m_action,
    output logic [1:0]         m_chosen_level,
    output logic [TIME_W-1:0]  m_boundary_ms,
    output logic [TIME_W-1:0]  m_retry_ms,
    output logic               m_cancel_failed,
    output logic [2:0]         m_reason_code,
    output logic [RATE_W-1:0]  m_smoothed_rate_bps
);
    // captured word
    logic               cmd_reg;
    logic [TIME_W-1:0]  now_reg, pres_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [RATE_W-1:0]  rep_reg;
    logic [2:0]         cur_reg, tgt_reg;
    logic [1:0]         ps_reg, ss_reg;
    logic [CNT_W-1:0]   scount_reg, sgen_reg;

    // persistent state
    logic [RATE_W-1:0]  smooth_reg, smooth_next;
    logic               svalid_reg, svalid_next;
    logic [TIME_W-1:0]  stime_reg, stime_next;
    logic [BYTES_W-1:0] sbytes_reg, sbytes_next;
    logic               dtim_reg, dtim_next, utim_reg, utim_next;
    logic [TIME_W-1:0]  dstart_reg, dstart_next, ustart_reg, ustart_next;
    logic               bvalid_reg, bvalid_next;
    logic [TIME_W-1:0]  buntil_reg, buntil_next;
    logic [7:0]         frun_reg, frun_next;
    logic [CNT_W-1:0]   seen_reg, seen_next, hgen_reg, hgen_next;

    // per-word working registers
    logic [1:0]         ract_reg, ract_next, rlvl_reg, rlvl_next;
    logic [TIME_W-1:0]  rbnd_reg, rbnd_next, rrty_reg, rrty_next;
    logic               rcnc_reg, rcnc_next;
    logic [2:0]         rrsn_reg, rrsn_next;
    logic [2:0]         swt_reg, swt_next, swr_reg, swr_next;
    logic               swi_reg, swi_next;
    logic [57:0]        bprod_reg;

    logic [2:0]         n;
    logic [DIVN_W-1:0]  div_n, div_q;
    logic [DIVD_W-1:0]  div_d;
    logic               div_done;

    logic               seen_chg, in_backoff;
    logic [7:0]         frun_b, frun_f, e;
    logic               bval_b;
    logic [14:0]        tspan;
    logic [TIME_W:0]    bsum;
    logic [TIME_W-1:0]  elapsed;
    logic               obs_meas;
    logic [BYTES_W-1:0] dbytes;
    logic [DIVN_W-1:0]  dbytes_x;
    logic [RATE_W-1:0]  meas;
    logic [RATE_W+1:0]  blend;
    logic [1:0]         up_idx;
    logic [RATE_W-1:0]  rate_cur, rate_up;
    logic [RATE_W+2:0]  s5, r6, s4, r7;
    logic               rebuf, low, room;
    logic [TIME_W-1:0]  dst_eff, ust_eff;
    logic               down_go, up_go, dec_sw;
    logic               sw_ok, sw_backoff, sw_div;
    logic [TIME_W:0]    bnum;
    logic [41:0]        qplus;

    function automatic logic dwell(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] st,
                                   input logic [TIME_W-1:0] span);
        logic [TIME_W-1:0] dt;
        dt = t - st;
        return (t >= st) && (dt >= span);
    endfunction

    assign n = (cfg.level_count > 3'(NUM_LEVELS)) ? 3'(NUM_LEVELS) : cfg.level_count;

    always_comb begin
        seen_chg = scount_reg != seen_reg;
        frun_b = seen_chg ? 8'd0 : frun_reg;
        bval_b = seen_chg ? 1'b0 : bvalid_reg;
        frun_f = (frun_b < 8'd255) ? frun_b + 8'd1 : frun_b;
        e = frun_f - 8'd1;
        tspan = (e >= 8'd3) ? 15'd30000 : (15'd5000 << e[1:0]);
        bsum = {1'b0, now_reg} + {{(TIME_W-14){1'b0}}, tspan};
        in_backoff = bvalid_reg && (now_reg < buntil_reg);

        elapsed = now_reg - stime_reg;
        dbytes = bytes_reg - sbytes_reg;
        obs_meas = svalid_reg && (now_reg >= stime_reg) && (elapsed >= TIME_W'(1000))
                   && (bytes_reg > sbytes_reg) && (rep_reg == '0);
        // times 8000 as 8192 - 128 - 64
        dbytes_x = ({13'd0, dbytes} << 13) - ({13'd0, dbytes} << 7)
                   - ({13'd0, dbytes} << 6);
        meas = (div_q > DIVN_W'(MAX40)) ? MAX40 : div_q[RATE_W-1:0];
        blend = (smooth_reg == '0) ? {2'b00, meas}
              : ({2'b00, smooth_reg} + {1'b0, smooth_reg, 1'b0} + {2'b00, meas}) >> 2;

        up_idx = cur_reg[1:0] + 2'd1;
        rate_cur = cfg.rate[cur_reg[1:0]];
        rate_up = cfg.rate[up_idx];
        s5 = {3'd0, smooth_reg} + {1'b0, smooth_reg, 2'b00};
        r6 = {1'b0, rate_cur, 2'b00} + {2'd0, rate_cur, 1'b0};
        s4 = {1'b0, smooth_reg, 2'b00};
        r7 = {rate_up, 3'b000} - {3'd0, rate_up};
        rebuf = ps_reg == PB_REBUFFER;
        low = rebuf || ((smooth_reg != '0) && (s5 < r6));
        room = (ps_reg == PB_READY) && (s4 >= r7);
        dst_eff = dtim_reg ? dstart_reg : now_reg;
        ust_eff = utim_reg ? ustart_reg : now_reg;
        down_go = (cur_reg != 3'd0) && low
                  && (rebuf || dwell(now_reg, dst_eff, TIME_W'(2000)));
        up_go = !((cur_reg != 3'd0) && low) && ({1'b0, cur_reg} + 4'd1 < {1'b0, n})
                && room && dwell(now_reg, ust_eff, TIME_W'(10000));
        dec_sw = !in_backoff && (cur_reg < n) && (down_go || up_go);

        sw_ok = (swt_reg < n) && (cfg.seg != '0) && (cfg.content != '0);
        sw_backoff = !swi_reg && in_backoff;
        sw_div = sw_ok && !sw_backoff;
        bnum = {1'b0, pres_reg} + {{(TIME_W-SEG_W+1){1'b0}}, cfg.seg} - 41'd1;
        qplus = {1'b0, div_q[40:0]} + 42'd4;
    end

    assign div_n = cmd.obs ? dbytes_x : {{(DIVN_W-TIME_W-1){1'b0}}, bnum};
    assign div_d = cmd.obs ? elapsed : {{(DIVD_W-SEG_W){1'b0}}, cfg.seg};

    ablsel_div #(.N(DIVN_W), .D(DIVD_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb begin
        sts.pre_sw = (cmd_reg == CMD_MANUAL) && !((tgt_reg < n) && (tgt_reg == cur_reg));
        sts.pre_obs = (cmd_reg == CMD_AUTO) && (n >= 3'd2) && (ss_reg == SS_STABLE);
        sts.obs_meas = obs_meas;
        sts.dec_sw = dec_sw;
        sts.sw_div = sw_div;
        sts.div_done = div_done;
    end

    always_comb begin
        smooth_next = smooth_reg;
        svalid_next = svalid_reg;
        stime_next = stime_reg;
        sbytes_next = sbytes_reg;
        dtim_next = dtim_reg;
        dstart_next = dstart_reg;
        utim_next = utim_reg;
        ustart_next = ustart_reg;
        bvalid_next = bvalid_reg;
        buntil_next = buntil_reg;
        frun_next = frun_reg;
        seen_next = seen_reg;
        hgen_next = hgen_reg;
        ract_next = ract_reg;
        rlvl_next = rlvl_reg;
        rbnd_next = rbnd_reg;
        rrty_next = rrty_reg;
        rcnc_next = rcnc_reg;
        rrsn_next = rrsn_reg;
        swt_next = swt_reg;
        swr_next = swr_reg;
        swi_next = swi_reg;

        if (cmd.load) begin
            ract_next = ACT_NONE;
            rlvl_next = '0;
            rbnd_next = '0;
            rrty_next = '0;
            rcnc_next = 1'b0;
            rrsn_next = RSN_NONE;
        end

        if (cmd.pre) begin
            if (cmd_reg == CMD_MANUAL) begin
                swt_next = tgt_reg;
                swr_next = RSN_MANUAL;
                swi_next = 1'b1;
            end else if (n >= 3'd2) begin
                if (seen_chg) begin
                    seen_next = scount_reg;
                    svalid_next = 1'b1;
                    stime_next = now_reg;
                    sbytes_next = bytes_reg;
                    dtim_next = 1'b0;
                    dstart_next = '0;
                    utim_next = 1'b0;
                    ustart_next = '0;
                    bvalid_next = 1'b0;
                    buntil_next = '0;
                    frun_next = '0;
                end
                if (ss_reg == SS_FAILED) begin
                    ract_next = ACT_RETRY;
                    rrsn_next = RSN_FAILED;
                    rrty_next = bval_b ? buntil_next : '0;
                    if (sgen_reg != hgen_reg) begin
                        hgen_next = sgen_reg;
                        frun_next = frun_f;
                        buntil_next = bsum[TIME_W] ? MAX40 : bsum[TIME_W-1:0];
                        bvalid_next = 1'b1;
                        rcnc_next = 1'b1;
                        rrty_next = buntil_next;
                    end
                    dtim_next = 1'b0;
                    dstart_next = '0;
                    utim_next = 1'b0;
                    ustart_next = '0;
                end
            end
        end

        if (cmd.obs) begin
            if (rep_reg != '0) smooth_next = rep_reg;
            if (!svalid_reg) begin
                svalid_next = 1'b1;
                stime_next = now_reg;
                sbytes_next = bytes_reg;
            end else if ((now_reg >= stime_reg) && (elapsed >= TIME_W'(1000))) begin
                stime_next = now_reg;
                sbytes_next = bytes_reg;
            end
        end

        if (cmd.mapply) smooth_next = blend[RATE_W-1:0];

        if (cmd.decide) begin
            if (in_backoff) begin
                ract_next = ACT_RETRY;
                rrty_next = buntil_reg;
                rrsn_next = RSN_BACKOFF;
            end else if (cur_reg < n) begin
                if ((cur_reg != 3'd0) && low) begin
                    if (!dtim_reg) begin
                        dtim_next = 1'b1;
                        dstart_next = now_reg;
                    end
                    swt_next = cur_reg - 3'd1;
                    swr_next = rebuf ? RSN_REBUF_DOWN : RSN_TPUT_DOWN;
                    swi_next = 1'b0;
                end else begin
                    dtim_next = 1'b0;
                    dstart_next = '0;
                    if ({1'b0, cur_reg} + 4'd1 < {1'b0, n}) begin
                        if (room) begin
                            if (!utim_reg) begin
                                utim_next = 1'b1;
                                ustart_next = now_reg;
                            end
                            swt_next = cur_reg + 3'd1;
                            swr_next = RSN_UPGRADE;
                            swi_next = 1'b0;
                        end else begin
                            utim_next = 1'b0;
                            ustart_next = '0;
                        end
                    end
                end
            end
        end

        if (cmd.sw && sw_ok && sw_backoff) begin
            ract_next = ACT_RETRY;
            rrty_next = buntil_reg;
            rrsn_next = RSN_BACKOFF;
        end

        // boundary at or past the content end gives no action
        if (cmd.bchk && (bprod_reg < {18'd0, cfg.content})) begin
            ract_next = ACT_SWITCH;
            rlvl_next = swt_reg[1:0];
            rbnd_next = bprod_reg[TIME_W-1:0];
            rrsn_next = swr_reg;
            dtim_next = 1'b0;
            dstart_next = '0;
            utim_next = 1'b0;
            ustart_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
            svalid_reg <= 1'b0;
            stime_reg <= '0;
            sbytes_reg <= '0;
            dtim_reg <= 1'b0;
            dstart_reg <= '0;
            utim_reg <= 1'b0;
            ustart_reg <= '0;
            bvalid_reg <= 1'b0;
            buntil_reg <= '0;
            frun_reg <= '0;
            seen_reg <= '0;
            hgen_reg <= '0;
        end else begin
            smooth_reg <= smooth_next;
            svalid_reg <= svalid_next;
            stime_reg <= stime_next;
            sbytes_reg <= sbytes_next;
            dtim_reg <= dtim_next;
            dstart_reg <= dstart_next;
            utim_reg <= utim_next;
            ustart_reg <= ustart_next;
            bvalid_reg <= bvalid_next;
            buntil_reg <= buntil_next;
            frun_reg <= frun_next;
            seen_reg <= seen_next;
            hgen_reg <= hgen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_command;
            now_reg <= s_now_ms;
            bytes_reg <= s_downloaded_bytes;
            rep_reg <= s_reported_rate_bps;
            cur_reg <= s_active_level;
            ps_reg <= s_playback_status;
            ss_reg <= s_switch_status;
            scount_reg <= s_switch_count;
            sgen_reg <= s_switch_generation;
            pres_reg <= s_presentation_ms;
            tgt_reg <= s_target_level;
        end
        ract_reg <= ract_next;
        rlvl_reg <= rlvl_next;
        rbnd_reg <= rbnd_next;
        rrty_reg <= rrty_next;
        rcnc_reg <= rcnc_next;
        rrsn_reg <= rrsn_next;
        swt_reg <= swt_next;
        swr_reg <= swr_next;
        swi_reg <= swi_next;
        if (cmd.bmul) bprod_reg <= qplus * {42'd0, cfg.seg};
        if (cmd.out_load) begin
            m_action <= ract_reg;
            m_chosen_level <= rlvl_reg;
            m_boundary_ms <= rbnd_reg;
            m_retry_ms <= rrty_reg;
            m_cancel_failed <= rcnc_reg;
            m_reason_code <= rrsn_reg;
            m_smoothed_rate_bps <= smooth_reg;
        end
    end
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// adaptive bitrate level selector testbench
// Drives observations and manual requests through the valid/ready input
// channel, with random gaps on both sides. A scoreboard class predicts each
// decision word and compares it field by field. Register settings are
// reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ablsel_pkg::*;

    typedef struct {
        logic               command;
        logic [TIME_W-1:0]  now_ms;
        logic [BYTES_W-1:0] bytes;
        logic [RATE_W-1:0]  rep_rate;
        logic [2:0]         active_level;
        logic [1:0]         playback;
        logic [1:0]         sw_status;
        logic [CNT_W-1:0]   sw_count;
        logic [CNT_W-1:0]   sw_gen;
        logic [TIME_W-1:0]  pres_ms;
        logic [2:0]         target;
    } obs_word_t;

    typedef struct {
        logic [1:0]        action;
        logic [1:0]        level;
        logic [TIME_W-1:0] boundary;
        logic [TIME_W-1:0] retry;
        logic              cancel;
        logic [2:0]        reason;
        logic [RATE_W-1:0] rate;
    } decision_t;

    class abr_scoreboard;
        logic [2:0]  lvl_count;
        logic [63:0] lvl_rate[4];
        logic [63:0] seg_len, content_len;
        logic [63:0] est_rate, smp_time, smp_bytes, dn_start, up_start_t;
        logic [63:0] bo_until, fail_run, seen_sw, handled_gen;
        bit          smp_valid, dn_on, up_on, bo_on;
        decision_t   pending[$];
        int          errors;
        int          checked;

        function void clear_all();
            lvl_count = 0; seg_len = 0; content_len = 0;
            foreach (lvl_rate[i]) lvl_rate[i] = 0;
            est_rate = 0; smp_valid = 0; smp_time = 0; smp_bytes = 0;
            clear_dwell();
            bo_on = 0; bo_until = 0; fail_run = 0; seen_sw = 0; handled_gen = 0;
            errors = 0; checked = 0;
        endfunction

        function void clear_dwell();
            dn_on = 0; dn_start = 0; up_on = 0; up_start_t = 0;
        endfunction

        function void set_reg(int idx, logic [63:0] v);
            case (idx)
                REG_LEVEL_COUNT: lvl_count = v[2:0];
                REG_RATE_0, REG_RATE_1, REG_RATE_2, REG_RATE_3:
                    lvl_rate[idx-1] = {24'd0, v[39:0]};
                REG_SEGMENT: seg_len = {48'd0, v[15:0]};
                REG_CONTENT: content_len = {24'd0, v[39:0]};
                default: ;
            endcase
        endfunction

        function logic [63:0] used_levels();
            return (lvl_count > NUM_LEVELS_DEF) ? NUM_LEVELS_DEF : lvl_count;
        endfunction

        function bit dwell_done(logic [63:0] now, logic [63:0] start, logic [63:0] span);
            return now >= start && now - start >= span;
        endfunction

        function void refresh_estimate(logic [63:0] now, logic [63:0] bytes,
                                       logic [63:0] rep);
            logic [63:0] d, m;
            if (rep > 0) est_rate = rep;
            if (!smp_valid) begin
                smp_valid = 1; smp_time = now; smp_bytes = bytes;
                return;
            end
            if (now < smp_time || now - smp_time < 1000) return;
            if (bytes >= smp_bytes && rep == 0) begin
                d = bytes - smp_bytes;
                if (d > 0) begin
                    m = d * 8000 / (now - smp_time);
                    if (m > {24'd0, MAX40}) m = {24'd0, MAX40};
                    est_rate = (est_rate == 0) ? m : (3 * est_rate + m) >> 2;
                end
            end
            smp_bytes = bytes; smp_time = now;
        endfunction

        function decision_t try_switch(logic [63:0] tgt, logic [63:0] now,
                                       logic [63:0] pres, logic [2:0] why, bit manual);
            decision_t r;
            logic [63:0] q, bnd;
            r = '{default: '0};
            if (tgt >= used_levels() || seg_len == 0 || content_len == 0) return r;
            if (!manual && bo_on && now < bo_until) begin
                r.action = ACT_RETRY; r.retry = bo_until[39:0]; r.reason = RSN_BACKOFF;
                return r;
            end
            q = (pres + seg_len - 1) / seg_len;
            bnd = (q + 4) * seg_len;
            if (bnd >= content_len) return r;
            r.action = ACT_SWITCH; r.level = tgt[1:0]; r.boundary = bnd[39:0];
            r.reason = why;
            clear_dwell();
            return r;
        endfunction

        function decision_t auto_step(obs_word_t w);
            decision_t r;
            logic [63:0] now, cur, n, e, t;
            bit rebuf, low, room;
            r = '{default: '0};
            now = {24'd0, w.now_ms};
            cur = {61'd0, w.active_level};
            n = used_levels();
            if (n < 2) return r;
            if ({32'd0, w.sw_count} != seen_sw) begin
                seen_sw = {32'd0, w.sw_count};
                smp_valid = 1; smp_time = now; smp_bytes = {16'd0, w.bytes};
                clear_dwell();
                bo_on = 0; bo_until = 0; fail_run = 0;
            end
            if (w.sw_status == SS_FAILED) begin
                r.action = ACT_RETRY;
                if ({32'd0, w.sw_gen} != handled_gen) begin
                    handled_gen = {32'd0, w.sw_gen};
                    if (fail_run < 255) fail_run++;
                    e = fail_run - 1;
                    t = (e >= 3) ? 30000 : (64'd5000 << e);
                    bo_until = (now + t > {24'd0, MAX40}) ? {24'd0, MAX40} : now + t;
                    bo_on = 1;
                    r.cancel = 1;
                end
                r.retry = bo_on ? bo_until[39:0] : '0;
                r.reason = RSN_FAILED;
                clear_dwell();
                return r;
            end
            if (w.sw_status != SS_STABLE) return r;
            refresh_estimate(now, {16'd0, w.bytes}, {24'd0, w.rep_rate});
            if (bo_on && now < bo_until) begin
                r.action = ACT_RETRY; r.retry = bo_until[39:0]; r.reason = RSN_BACKOFF;
                return r;
            end
            if (cur >= n) return r;
            if (cur > 0) begin
                rebuf = (w.playback == PB_REBUFFER);
                low = rebuf || (est_rate > 0 && est_rate * 5 < lvl_rate[cur[1:0]] * 6);
                if (low) begin
                    if (!dn_on) begin
                        dn_on = 1; dn_start = now;
                    end
                    if (rebuf || dwell_done(now, dn_start, 2000))
                        return try_switch(cur - 1, now, {24'd0, w.pres_ms},
                                          rebuf ? RSN_REBUF_DOWN : RSN_TPUT_DOWN, 0);
                    return r;
                end
            end
            dn_on = 0; dn_start = 0;
            if (cur + 1 < n) begin
                room = (w.playback == PB_READY) &&
                       est_rate * 4 >= lvl_rate[cur[1:0] + 2'd1] * 7;
                if (room) begin
                    if (!up_on) begin
                        up_on = 1; up_start_t = now;
                    end
                    if (dwell_done(now, up_start_t, 10000))
                        return try_switch(cur + 1, now, {24'd0, w.pres_ms},
                                          RSN_UPGRADE, 0);
                end else begin
                    up_on = 0; up_start_t = 0;
                end
            end
            return r;
        endfunction

        function void note_input(obs_word_t w);
            decision_t r;
            if (w.command == CMD_MANUAL) begin
                r = '{default: '0};
                if (!({61'd0, w.target} < used_levels() && w.target == w.active_level))
                    r = try_switch({61'd0, w.target}, {24'd0, w.now_ms},
                                   {24'd0, w.pres_ms}, RSN_MANUAL, 1);
            end else begin
                r = auto_step(w);
            end
            r.rate = est_rate[39:0];
            pending.push_back(r);
        endfunction

        function void check_result(decision_t got);
            decision_t x;
            if (pending.size() == 0) begin
                $error("decision word with nothing expected");
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (got.action !== x.action) begin
                $error("action: expected %0d, got %0d", x.action, got.action); errors++;
            end
            if (got.level !== x.level) begin
                $error("chosen_level: expected %0d, got %0d", x.level, got.level); errors++;
            end
            if (got.boundary !== x.boundary) begin
                $error("boundary_ms: expected %0d, got %0d", x.boundary, got.boundary);
                errors++;
            end
            if (got.retry !== x.retry) begin
                $error("retry_ms: expected %0d, got %0d", x.retry, got.retry); errors++;
            end
            if (got.cancel !== x.cancel) begin
                $error("cancel_failed: expected %0d, got %0d", x.cancel, got.cancel);
                errors++;
            end
            if (got.reason !== x.reason) begin
                $error("reason_code: expected %0d, got %0d", x.reason, got.reason); errors++;
            end
            if (got.rate !== x.rate) begin
                $error("smoothed_rate_bps: expected %0d, got %0d", x.rate, got.rate);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_command = 0;
    logic [TIME_W-1:0]  s_now_ms = '0;
    logic [BYTES_W-1:0] s_downloaded_bytes = '0;
    logic [RATE_W-1:0]  s_reported_rate_bps = '0;
    logic [2:0]         s_active_level = '0;
    logic [1:0]         s_playback_status = '0;
    logic [1:0]         s_switch_status = '0;
    logic [CNT_W-1:0]   s_switch_count = '0;
    logic [CNT_W-1:0]   s_switch_generation = '0;
    logic [TIME_W-1:0]  s_presentation_ms = '0;
    logic [2:0]         s_target_level = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [1:0]         m_action;
    logic [1:0]         m_chosen_level;
    logic [TIME_W-1:0]  m_boundary_ms;
    logic [TIME_W-1:0]  m_retry_ms;
    logic               m_cancel_failed;
    logic [2:0]         m_reason_code;
    logic [RATE_W-1:0]  m_smoothed_rate_bps;

    adaptive_bitrate_level_selector_top DUT (.*);

    always #4 aclk = ~aclk;

    abr_scoreboard sb = new();

    // player-side view used to build plausible observations
    logic [63:0] clk_ms, pres_ms, byte_cnt;
    logic [31:0] sw_cnt, sw_gen;
    logic [2:0]  playing_level;
    logic [63:0] rates[4];
    bit          no_idle;
    int          words_sent;

    function logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(obs_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_command <= w.command;
        s_now_ms <= w.now_ms;
        s_downloaded_bytes <= w.bytes;
        s_reported_rate_bps <= w.rep_rate;
        s_active_level <= w.active_level;
        s_playback_status <= w.playback;
        s_switch_status <= w.sw_status;
        s_switch_count <= w.sw_count;
        s_switch_generation <= w.sw_gen;
        s_presentation_ms <= w.pres_ms;
        s_target_level <= w.target;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic directed(logic cmd, logic [63:0] now, logic [63:0] bytes,
                            logic [63:0] rep, logic [2:0] lvl, logic [1:0] pb,
                            logic [1:0] ss, logic [31:0] cnt, logic [31:0] gen,
                            logic [63:0] pres, logic [2:0] tgt);
        obs_word_t w;
        w = '{cmd, now[39:0], bytes[47:0], rep[39:0], lvl, pb, ss, cnt, gen,
              pres[39:0], tgt};
        send_word(w);
    endtask

    task automatic apb_write(int idx, logic [63:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_AW'(idx * 8); pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        // last word already taken, so drop valid before waiting
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic program_phase(int p);
        logic [63:0] cnt, seg, cont, base;
        case (p)
            0: begin cnt = 4; seg = 2000; cont = 64'hFF_FFFF_FFFF - 1; base = 500000; end
            1: begin cnt = 7; seg = 65535; cont = 64'hFF_FFFF_FFFF; base = 2000000; end
            2: begin cnt = 2; seg = 1; cont = 40000; base = 100000; end
            3: begin
                cnt = 64'($urandom_range(0, 1)); seg = 0; cont = 1000000; base = 800000;
            end
            4: begin cnt = 3; seg = 4000; cont = 0; base = 64'h3F_FFFF_FFFF; end
            5: begin cnt = 4; seg = 1000; cont = 64'hFF_FFFF_FFFF; base = 1; end
            default: begin
                cnt = 64'($urandom_range(0, 7)); seg = 64'($urandom_range(0, 65535));
                cont = rnd64() & 64'hFF_FFFF_FFFF;
                base = 64'($urandom_range(1000, 5000000));
            end
        endcase
        rates[0] = base;
        rates[1] = base * 3;
        rates[2] = base * 3;
        rates[3] = (p == 4) ? 64'hFF_FFFF_FFFF : base * 4;
        if (p != 4) begin
            rates[2] = base * 7 / 2;
            rates[3] = base * 9;
        end
        // upper bits of the data word must be dropped by the block
        apb_write(REG_LEVEL_COUNT, cnt | (rnd64() << 3));
        for (int i = 0; i < 4; i++) apb_write(REG_RATE_0 + i, rates[i] & 64'hFF_FFFF_FFFF);
        apb_write(REG_SEGMENT, seg);
        apb_write(REG_CONTENT, cont);
    endtask

    function obs_word_t next_word();
        obs_word_t w;
        int sel;
        logic [63:0] dt, tput, rn;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            // noise word with every field at full width
            w.command = 1'($urandom);
            rn = rnd64(); w.now_ms = rn[39:0];
            rn = rnd64(); w.bytes = rn[47:0];
            rn = rnd64(); w.rep_rate = rn[39:0];
            w.active_level = 3'($urandom); w.playback = 2'($urandom);
            w.sw_status = 2'($urandom); w.sw_count = $urandom; w.sw_gen = $urandom;
            rn = rnd64(); w.pres_ms = rn[39:0];
            w.target = 3'($urandom);
            return w;
        end
        dt = 64'($urandom_range(0, 2500));
        if ($urandom_range(0, 49) == 0) clk_ms = clk_ms - $urandom_range(1, 3000);
        else clk_ms = clk_ms + dt;
        pres_ms = pres_ms + $urandom_range(0, 2500);
        tput = rates[$urandom_range(0, 3)] * $urandom_range(3, 20) / 8;
        if ($urandom_range(0, 29) == 0) byte_cnt = byte_cnt - $urandom_range(1, 100000);
        else byte_cnt = byte_cnt + tput * dt / 8000;
        if ($urandom_range(0, 29) == 0) sw_cnt++;
        w.command = ($urandom_range(0, 99) < 7) ? CMD_MANUAL : CMD_AUTO;
        w.now_ms = clk_ms[39:0];
        w.bytes = byte_cnt[47:0];
        w.rep_rate = ($urandom_range(0, 9) == 0) ? tput[39:0] : '0;
        w.active_level = ($urandom_range(0, 9) == 0) ? 3'($urandom) : playing_level;
        sel = $urandom_range(0, 99);
        w.playback = (sel < 80) ? PB_READY : (sel < 88) ? PB_REBUFFER : 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            w.sw_status = SS_FAILED;
            if ($urandom_range(0, 9) < 7) sw_gen++;
        end else if (sel < 10) begin
            w.sw_status = 2'($urandom_range(2, 3));
        end else begin
            w.sw_status = SS_STABLE;
        end
        w.sw_count = sw_cnt;
        w.sw_gen = sw_gen;
        w.pres_ms = pres_ms[39:0];
        w.target = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
        return w;
    endfunction

    // result side: random stalls between decision words
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result('{m_action, m_chosen_level, m_boundary_ms, m_retry_ms,
                              m_cancel_failed, m_reason_code, m_smoothed_rate_bps});
            if (m_action == ACT_SWITCH) playing_level <= {1'b0, m_chosen_level};
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sb.clear_all();
        clk_ms = 100000; pres_ms = 0; byte_cnt = 0; sw_cnt = 0; sw_gen = 0;
        playing_level = 0; no_idle = 0; words_sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        program_phase(0);
        // first sample, first measurement, reported rate, short interval
        directed(CMD_AUTO, 100000, 0, 0, 0, PB_READY, SS_STABLE, 0, 0, 0, 0);
        directed(CMD_AUTO, 101500, 900000, 0, 0, PB_READY, SS_STABLE, 0, 0, 1000, 0);
        directed(CMD_AUTO, 102000, 950000, 3000000, 0, PB_READY, SS_STABLE, 0, 0, 1500, 0);
        directed(CMD_AUTO, 102400, 990000, 0, 0, PB_READY, SS_STABLE, 0, 0, 1900, 0);
        // clock going backwards, then byte count going backwards
        directed(CMD_AUTO, 90000, 1000000, 0, 1, PB_READY, SS_STABLE, 0, 0, 2000, 0);
        directed(CMD_AUTO, 104000, 10, 0, 1, PB_READY, SS_STABLE, 0, 0, 2500, 0);
        // failure without new generation, then four fresh failures
        directed(CMD_AUTO, 105000, 20, 0, 1, PB_READY, SS_FAILED, 0, 0, 3000, 0);
        for (int i = 1; i <= 4; i++)
            directed(CMD_AUTO, 105000 + i, 20, 0, 1, PB_READY, SS_FAILED, 0, i, 3000, 0);
        directed(CMD_AUTO, 106000, 30, 0, 1, PB_READY, SS_STABLE, 0, 4, 3100, 0);
        // manual ignores backoff; manual on active and out of range do nothing
        directed(CMD_MANUAL, 106100, 30, 0, 1, PB_READY, SS_STABLE, 0, 4, 3200, 2);
        directed(CMD_MANUAL, 106200, 30, 0, 2, PB_READY, SS_STABLE, 0, 4, 3300, 2);
        directed(CMD_MANUAL, 106300, 30, 0, 2, PB_READY, SS_STABLE, 0, 4, 3300, 4);
        directed(CMD_MANUAL, 106400, 30, 0, 2, PB_READY, SS_STABLE, 0, 4, 3300, 7);
        // switch count moves on: backoff cleared, then rebuffer step down
        directed(CMD_AUTO, 107000, 40, 0, 2, PB_READY, SS_STABLE, 1, 4, 3400, 0);
        directed(CMD_AUTO, 108000, 50, 0, 2, PB_REBUFFER, SS_STABLE, 1, 4, 3500, 0);
        directed(CMD_AUTO, 109000, 60, 0, 1, 2'd3, 2'd2, 1, 4, 3600, 0);
        directed(CMD_AUTO, 109100, 60, 0, 1, 2'd0, 2'd3, 1, 4, 3600, 0);
        directed(CMD_AUTO, 64'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 3'd7,
                 2'd3, SS_FAILED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFF_FFFF_FFFF, 3'd7);
        directed(CMD_MANUAL, 64'hFF_FFFF_FFFF, 0, 0, 3'd0, 2'd0, SS_STABLE, 0, 0,
                 64'hFF_FFFF_FFFF, 3'd1);
        directed(CMD_MANUAL, 0, 0, 0, 0, 0, SS_STABLE, 0, 0, 0, 3);
        directed(CMD_AUTO, 0, 0, 0, 0, 0, SS_STABLE, 0, 0, 0, 0);
        clk_ms = 200000; byte_cnt = 1000; sw_cnt = 5; pres_ms = 0;

        for (int p = 0; p < 7; p++) begin
            drain();
            if (p > 0) program_phase(p);
            for (int k = 0; k < 270; k++) begin
                if (k % 45 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_word(next_word());
            end
            no_idle = 0;
        end
        drain();

        if (sb.pending.size() != 0) begin
            $error("%0d decision words never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("run covered %0d words over seven register settings, %0d decisions checked",
                 words_sent, sb.checked);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
